/* hw/rtl/fcm_pkg.sv */
// Shared types, constants and command/status structs for the FAT chain manager.
package fcm_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TAG_W      = 2;
    localparam int ENT_W      = TAG_W + IDX_W;

    // Request kinds
    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_SEEK   = 2'd2,
        FUNC_TRUNC  = 2'd3
    } t_func;

    // Table entry tags
    typedef enum logic [TAG_W-1:0] {
        TAG_FREE = 2'd0,
        TAG_END  = 2'd1,
        TAG_LINK = 2'd2
    } t_tag;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_END_EARLY = 2'd2
    } t_status;

    // Table read address source
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_SCAN
    } t_rd_sel;

    // Table write kind
    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_CUR_FREE,
        WR_CUR_END,
        WR_TAIL_LINK
    } t_wr_sel;

    // Step counter operation
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } t_cnt_op;

    // Result block source
    typedef enum logic {
        BLK_ZERO,
        BLK_IDX
    } t_blk_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load_req;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_cnt_op  cnt_op;
        logic     set_tail;
        logic     set_keep;
        logic     res_set;
        t_blk_sel blk_sel;
        t_status  res_st;
        logic     load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_func            func;
        logic             present;
        logic [TAG_W-1:0] tag;
        logic             walk_done;
        logic             cnt_last;
        logic             idx_last;
        logic             idx_is_tail;
        logic             idx_is_keep;
        logic             out_room;
    } t_sts;

endpackage

/* hw/rtl/fat_chain_manager_top.sv */
// Top level of the FAT chain manager: stream ports, controller and datapath.
//
//  channel  | direction | tdata                                    | tuser
//  s_axis   | in        | [11:0] chain_head, [23:12] block_position | [1:0] func, [2] head_present
//  m_axis   | out       | [11:0] block_index, [15:12] zero          | [1:0] status
//
// One request at a time; the table has a read port and a write port, usable in the same cycle.
// Ready returns in the cycle after the result is loaded. Append walks the chain from the
// head, if one is given, then scans up from block 0 for the lowest free block; free chain,
// seek and truncate follow the chain from the head block by block.
// After reset a clearing pass writes all 4096 entries free (s_axis_tready low).
// A result waits in the output register; the next request is taken meanwhile but
// completes only once that register has been emptied.
module fat_chain_manager_top import fcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] chain_head, [23:12] block_position
    input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] head_present
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] block_index, [15:12] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    t_cmd             cmd;
    t_sts             sts;
    logic [IDX_W-1:0] block_index;

    fcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    fcm_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (s_axis_tuser[1:0]),
        .i_chain_head     (s_axis_tdata[11:0]),
        .i_head_present   (s_axis_tuser[2]),
        .i_block_position (s_axis_tdata[23:12]),
        .i_out_ready      (m_axis_tready),
        .o_sts            (sts),
        .o_out_valid      (m_axis_tvalid),
        .o_block_index    (block_index),
        .o_status         (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0, block_index};

    // Ready drops right after reset for the clearing pass
    a_clear_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clearing pass");

    // Only one request in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    // A failed allocation reports block zero
    a_no_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_NO_FREE)) |-> (m_axis_tdata == 16'd0))
        else $error("no free block result with nonzero index");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status code");

endmodule

/* hw/rtl/fcm_datapath.sv */
// Datapath: allocation table memory, request registers, step counter and result register.
module fcm_datapath import fcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_func,
    input  logic [IDX_W-1:0] i_chain_head,
    input  logic             i_head_present,
    input  logic [IDX_W-1:0] i_block_position,
    input  logic             i_out_ready,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output logic [IDX_W-1:0] o_block_index,
    output logic [1:0]       o_status
);

    logic [ENT_W-1:0] r_mem [NUM_BLOCKS];

    t_func            r_func;
    logic [IDX_W-1:0] r_head;
    logic             r_present;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_tail;
    logic [IDX_W-1:0] r_keep;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [ENT_W-1:0] r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_blk;
    t_status          r_st;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_blk;
    t_status          r_out_st;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_next;
    logic [CNT_W-1:0] walk_limit;

    assign rd_next = r_rd_data[IDX_W-1:0];

    // Select the table read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_HEAD: rd_addr = r_head;
            RD_NEXT: rd_addr = rd_next;
            RD_SCAN: rd_addr = r_cnt[IDX_W-1:0];
            default: rd_addr = r_head;
        endcase
    end

    // Select the table write address and entry
    always_comb begin
        case (i_cmd.wr_sel)
            WR_CLEAR: begin
                wr_addr = r_cnt[IDX_W-1:0];
                wr_data = '0;
            end
            WR_CUR_FREE: begin
                wr_addr = r_rd_idx;
                wr_data = {TAG_FREE, {IDX_W{1'b0}}};
            end
            WR_CUR_END: begin
                wr_addr = r_rd_idx;
                wr_data = {TAG_END, {IDX_W{1'b0}}};
            end
            WR_TAIL_LINK: begin
                wr_addr = r_tail;
                wr_data = {TAG_LINK, r_blk};
            end
            default: begin
                wr_addr = r_rd_idx;
                wr_data = '0;
            end
        endcase
    end

    // Table memory, read data registered, a same-cycle write is passed through
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= (i_cmd.wr_en && (wr_addr == rd_addr)) ? wr_data : r_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    // Hold request fields, tail, kept block and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func    <= t_func'(i_func);
            r_head    <= i_chain_head;
            r_present <= i_head_present;
            r_pos     <= i_block_position;
        end
        if (i_cmd.set_tail) begin
            r_tail <= r_rd_idx;
        end
        if (i_cmd.set_keep) begin
            r_keep <= r_rd_idx;
        end
        if (i_cmd.res_set) begin
            r_blk <= (i_cmd.blk_sel == BLK_IDX) ? r_rd_idx : '0;
            r_st  <= i_cmd.res_st;
        end
    end

    // Advance the step counter
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_CLR: n_cnt = '0;
            CNT_INC: n_cnt = r_cnt + CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Result register toward the output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_blk <= r_blk;
            r_out_st  <= r_st;
        end
    end

    // Append walks at most the table size, seek and truncate walk the position
    assign walk_limit = (r_func == FUNC_APPEND) ? CNT_W'(NUM_BLOCKS) : {1'b0, r_pos};

    // Status toward the controller
    always_comb begin
        o_sts.func        = r_func;
        o_sts.present     = r_present;
        o_sts.tag         = r_rd_data[ENT_W-1:IDX_W];
        o_sts.walk_done   = (r_cnt == walk_limit);
        o_sts.cnt_last    = (r_cnt == CNT_W'(NUM_BLOCKS - 1));
        o_sts.idx_last    = (r_rd_idx == IDX_W'(NUM_BLOCKS - 1));
        o_sts.idx_is_tail = (r_rd_idx == r_tail);
        o_sts.idx_is_keep = (r_rd_idx == r_keep);
        o_sts.out_room    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_index = r_out_blk;
    assign o_status      = r_out_st;

endmodule

/* hw/rtl/fcm_ctrl.sv */
// Controller: sequences the clearing pass, chain walks, free scan and table updates.
module fcm_ctrl import fcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK,
        S_FREE,
        S_TRUNC,
        S_SCAN_START,
        S_SCAN,
        S_LINK_TAIL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   not_link;
    logic   is_free;

    assign not_link = (i_sts.tag != TAG_LINK);
    assign is_free  = (i_sts.tag == TAG_FREE);

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_HEAD;
        o_cmd.wr_sel   = WR_CLEAR;
        o_cmd.cnt_op   = CNT_HOLD;
        o_cmd.blk_sel  = BLK_ZERO;
        o_cmd.res_st   = ST_OK;

        unique case (r_state)
            // Write every entry free, one per cycle
            S_CLEAR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_CLEAR;
                o_cmd.cnt_op = CNT_INC;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_START;
                end
            end
            // Dispatch on the request kind
            S_START: begin
                o_cmd.cnt_op = CNT_CLR;
                unique case (i_sts.func) inside
                    FUNC_APPEND: begin
                        if (i_sts.present) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = S_WALK;
                        end else begin
                            n_state = S_SCAN_START;
                        end
                    end
                    FUNC_FREE: begin
                        if (i_sts.present) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = S_FREE;
                        end else begin
                            o_cmd.res_set = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    FUNC_SEEK, FUNC_TRUNC: begin
                        if (i_sts.present) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = S_WALK;
                        end else begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_st  = ST_END_EARLY;
                            n_state       = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // Follow one link per cycle
            S_WALK: begin
                if (i_sts.func == FUNC_APPEND) begin
                    if (i_sts.walk_done || not_link) begin
                        o_cmd.set_tail = 1'b1;
                        o_cmd.cnt_op   = CNT_CLR;
                        n_state        = S_SCAN_START;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_NEXT;
                        o_cmd.cnt_op = CNT_INC;
                    end
                end else if (i_sts.walk_done) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.blk_sel = BLK_IDX;
                    o_cmd.res_st  = ST_OK;
                    n_state       = S_DONE;
                    if (i_sts.func == FUNC_TRUNC) begin
                        // End the chain here and release what follows
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.wr_sel   = WR_CUR_END;
                        o_cmd.set_keep = 1'b1;
                        if (!not_link) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_NEXT;
                            o_cmd.cnt_op = CNT_CLR;
                            n_state      = S_TRUNC;
                        end
                    end
                end else if (not_link) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.blk_sel = BLK_IDX;
                    o_cmd.res_st  = ST_END_EARLY;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            // Release the chain one block per cycle
            S_FREE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_CUR_FREE;
                if (not_link || i_sts.cnt_last) begin
                    o_cmd.res_set = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            // Release blocks past the kept one, stop on a loop back to it
            S_TRUNC: begin
                if (i_sts.idx_is_keep) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_CUR_FREE;
                    if (not_link || i_sts.cnt_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_NEXT;
                        o_cmd.cnt_op = CNT_INC;
                    end
                end
            end
            // Prime the scan pipeline with block 0
            S_SCAN_START: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SCAN;
                o_cmd.cnt_op = CNT_INC;
                n_state      = S_SCAN;
            end
            // Check one entry per cycle for the lowest free block
            S_SCAN: begin
                if (is_free && !(i_sts.present && i_sts.idx_is_tail)) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_CUR_END;
                    o_cmd.res_set = 1'b1;
                    o_cmd.blk_sel = BLK_IDX;
                    o_cmd.res_st  = ST_OK;
                    n_state       = i_sts.present ? S_LINK_TAIL : S_DONE;
                end else if (i_sts.idx_last) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_st  = ST_NO_FREE;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SCAN;
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            // Link the old tail to the new block
            S_LINK_TAIL: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_TAIL_LINK;
                n_state      = S_DONE;
            end
            // Hand the result to the output register once it has room
            S_DONE: begin
                if (i_sts.out_room) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule
